/* rtl/core/qrbm_pkg.sv */
// Shared types, codes and the capacity table of the QR byte-mode codeword packer.
package qrbm_pkg;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DATA,
		PH_DRAIN
	} phase_t;

	// request codes carried in tuser
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_DATA  = 2'd1;
	localparam logic [1:0] REQ_DRAIN = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TOO_LONG = 2'd1;
	localparam logic [1:0] ST_ORDER    = 2'd2;

	// configuration register indexes
	localparam logic CFG_EC_LEVEL = 1'b0;
	localparam logic CFG_VERSION  = 1'b1;

	localparam logic [3:0] MODE_BYTE   = 4'h4;
	localparam logic [7:0] PAD_A       = 8'hEC;
	localparam logic [7:0] PAD_B       = 8'h11;
	localparam logic [5:0] SHORT_LIMIT = 6'd9;   // versions 1..9 use an 8-bit count

	localparam int OUT_DEPTH = 2;
	localparam int PTR_W     = $clog2(OUT_DEPTH);
	localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  data_byte;
		logic [11:0] msg_length;
	} item_t;

	typedef struct packed {
		logic [7:0] codeword;
		logic       codeword_valid;
		logic       last;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		logic [11:0] cap;
		logic        short_count;
	} cap_info_t;

	// byte capacity per level (row) and version (column)
	localparam logic [11:0] CAP_ROM [4][40] = '{
		'{12'd17, 12'd32, 12'd53, 12'd78, 12'd106, 12'd134, 12'd154, 12'd192,
		  12'd230, 12'd271, 12'd321, 12'd367, 12'd425, 12'd458, 12'd520, 12'd586,
		  12'd644, 12'd718, 12'd792, 12'd858, 12'd929, 12'd1003, 12'd1091, 12'd1171,
		  12'd1273, 12'd1367, 12'd1465, 12'd1528, 12'd1628, 12'd1732, 12'd1840,
		  12'd1952, 12'd2068, 12'd2188, 12'd2303, 12'd2431, 12'd2563, 12'd2699,
		  12'd2809, 12'd2953},
		'{12'd14, 12'd26, 12'd42, 12'd62, 12'd84, 12'd106, 12'd122, 12'd152,
		  12'd180, 12'd213, 12'd251, 12'd287, 12'd331, 12'd362, 12'd412, 12'd450,
		  12'd504, 12'd560, 12'd624, 12'd666, 12'd711, 12'd779, 12'd857, 12'd911,
		  12'd997, 12'd1059, 12'd1125, 12'd1190, 12'd1264, 12'd1370, 12'd1452,
		  12'd1538, 12'd1628, 12'd1722, 12'd1809, 12'd1911, 12'd1989, 12'd2099,
		  12'd2213, 12'd2331},
		'{12'd11, 12'd20, 12'd32, 12'd46, 12'd60, 12'd74, 12'd86, 12'd108,
		  12'd130, 12'd151, 12'd177, 12'd203, 12'd241, 12'd258, 12'd292, 12'd322,
		  12'd364, 12'd394, 12'd442, 12'd482, 12'd509, 12'd565, 12'd611, 12'd661,
		  12'd715, 12'd751, 12'd805, 12'd868, 12'd908, 12'd982, 12'd1030,
		  12'd1112, 12'd1168, 12'd1228, 12'd1283, 12'd1351, 12'd1423, 12'd1499,
		  12'd1579, 12'd1663},
		'{12'd7, 12'd14, 12'd24, 12'd34, 12'd44, 12'd58, 12'd64, 12'd84,
		  12'd98, 12'd119, 12'd137, 12'd155, 12'd177, 12'd194, 12'd220, 12'd250,
		  12'd280, 12'd310, 12'd338, 12'd382, 12'd403, 12'd439, 12'd461, 12'd511,
		  12'd535, 12'd593, 12'd625, 12'd658, 12'd698, 12'd742, 12'd790,
		  12'd842, 12'd898, 12'd958, 12'd983, 12'd1051, 12'd1093, 12'd1139,
		  12'd1219, 12'd1273}
	};

endpackage

/* rtl/core/qr_byte_mode_codeword_packer_top.sv */
// Top level of the QR byte-mode data codeword packer.
// An accepted item is registered, and its results pass the output queue to m_tvalid.
// Throughput: one item per cycle while the queue has room; an accepted start item at
//   version index 9 or more holds the engine, as its two header codewords share one queue write port.
// Reset (arst_n low): stream goes idle, queue empties, ec_level and version_index
//   return to 0; the capacity register has no reset and reloads on every clock.
module qr_byte_mode_codeword_packer_top #(
	parameter int VERSION_COUNT = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] data_byte, [19:8] msg_length, [23:20] zero
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] codeword
	output logic [2:0]  m_tuser,   // [0] codeword_valid, [2:1] status
	output logic        m_tlast,   // last codeword of the symbol data
	// configuration writes
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [5:0]  cfg_wdata
);

	logic [1:0] ec_level_q;
	logic [5:0] version_index_q;
	logic [1:0] ec_level_next;
	logic [5:0] version_index_next;

	qrbm_pkg::item_t     in_item;
	qrbm_pkg::cap_info_t cap_info;
	qrbm_pkg::result_t   push_res;
	qrbm_pkg::result_t   out_res;
	logic                push;
	logic                out_full;

	// The ROM is addressed with the value being written so that the capacity is
	// already current for an item taken right after a configuration write.
	assign ec_level_next = (cfg_we && cfg_addr == qrbm_pkg::CFG_EC_LEVEL) ?
		cfg_wdata[1:0] : ec_level_q;
	assign version_index_next = (cfg_we && cfg_addr == qrbm_pkg::CFG_VERSION) ?
		cfg_wdata : version_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ec_level_q      <= 2'd0;
			version_index_q <= 6'd0;
		end else begin
			ec_level_q      <= ec_level_next;
			version_index_q <= version_index_next;
		end
	end

	assign in_item.req_type   = s_tuser;
	assign in_item.data_byte  = s_tdata[7:0];
	assign in_item.msg_length = s_tdata[19:8];

	qrbm_cap_rom #(
		.VERSION_COUNT(VERSION_COUNT)
	) u_cap_rom (
		.clk          (clk),
		.ec_level     (ec_level_next),
		.version_index(version_index_next),
		.cap_info     (cap_info)
	);

	qrbm_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_item (in_item),
		.cap_info(cap_info),
		.out_full(out_full),
		.push    (push),
		.push_res(push_res)
	);

	qrbm_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_res (push_res),
		.full     (out_full),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (out_res)
	);

	assign m_tdata = out_res.codeword;
	assign m_tuser = {out_res.status, out_res.codeword_valid};
	assign m_tlast = out_res.last;

endmodule

/* rtl/core/qrbm_cap_rom.sv */
// Capacity ROM with registered read, addressed by level and clamped version.
module qrbm_cap_rom #(
	parameter int VERSION_COUNT = 40
) (
	input  logic                 clk,
	input  logic [1:0]           ec_level,
	input  logic [5:0]           version_index,
	output qrbm_pkg::cap_info_t  cap_info
);

	localparam logic [5:0] VI_MAX = 6'(VERSION_COUNT - 1);

	logic [5:0]          vi;
	qrbm_pkg::cap_info_t cap_q;

	always_comb begin
		vi = (version_index > VI_MAX) ? VI_MAX : version_index;
	end

	always_ff @(posedge clk) begin
		cap_q.cap         <= qrbm_pkg::CAP_ROM[ec_level][vi];
		cap_q.short_count <= (vi < qrbm_pkg::SHORT_LIMIT);
	end

	assign cap_info = cap_q;

endmodule

/* rtl/core/qrbm_engine.sv */
// Input stage and packing engine: holds the stream state and forms one result a cycle unless the queue is full.
module qrbm_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  qrbm_pkg::item_t      in_item,
	input  qrbm_pkg::cap_info_t  cap_info,
	input  logic                 out_full,
	output logic                 push,
	output qrbm_pkg::result_t    push_res
);

	logic              valid_s1;
	qrbm_pkg::item_t   item_s1;

	qrbm_pkg::phase_t  phase_q, phase_d;
	logic [3:0]        held_q, held_d;
	logic [11:0]       bytes_left_q, bytes_left_d;
	logic [11:0]       pads_left_q, pads_left_d;
	logic              term_q, term_d;
	logic              toggle_q, toggle_d;
	logic              hdr2_q, hdr2_d;      // second header codeword still owed
	logic [7:0]        hdr2_byte_q, hdr2_byte_d;

	logic fire;
	logic too_long;
	logic data_ok;
	logic drain_last;

	assign fire       = valid_s1 && !hdr2_q && !out_full;
	assign in_ready   = !valid_s1 || fire;
	assign push       = fire || (hdr2_q && !out_full);
	assign too_long   = item_s1.msg_length > cap_info.cap;
	assign data_ok    = (phase_q == qrbm_pkg::PH_DATA) && (bytes_left_q != 12'd0);
	assign drain_last = term_q ? (pads_left_q <= 12'd1) : (pads_left_q == 12'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	always_comb begin : next_state
		phase_d      = phase_q;
		held_d       = held_q;
		bytes_left_d = bytes_left_q;
		pads_left_d  = pads_left_q;
		term_d       = term_q;
		toggle_d     = toggle_q;
		hdr2_d       = hdr2_q;
		hdr2_byte_d  = hdr2_byte_q;
		if (hdr2_q && !out_full) begin
			hdr2_d = 1'b0;
		end
		if (fire) begin
			unique case (item_s1.req_type)
				qrbm_pkg::REQ_START: begin
					if (phase_q == qrbm_pkg::PH_IDLE && !too_long) begin
						bytes_left_d = item_s1.msg_length;
						pads_left_d  = cap_info.cap - item_s1.msg_length;
						term_d       = 1'b0;
						toggle_d     = 1'b0;
						held_d       = item_s1.msg_length[3:0];
						phase_d      = (item_s1.msg_length == 12'd0) ?
							qrbm_pkg::PH_DRAIN : qrbm_pkg::PH_DATA;
						if (!cap_info.short_count) begin
							hdr2_d      = 1'b1;
							hdr2_byte_d = item_s1.msg_length[11:4];
						end
					end
				end
				qrbm_pkg::REQ_DATA: begin
					if (data_ok) begin
						held_d       = item_s1.data_byte[3:0];
						bytes_left_d = bytes_left_q - 12'd1;
						if (bytes_left_q == 12'd1) begin
							phase_d = qrbm_pkg::PH_DRAIN;
						end
					end
				end
				qrbm_pkg::REQ_DRAIN: begin
					if (phase_q == qrbm_pkg::PH_DRAIN) begin
						if (!term_q) begin
							term_d = 1'b1;
						end else begin
							toggle_d = ~toggle_q;
							if (pads_left_q != 12'd0) begin
								pads_left_d = pads_left_q - 12'd1;
							end
						end
						if (drain_last) begin
							phase_d = qrbm_pkg::PH_IDLE;
							held_d  = 4'd0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin : result_out
		push_res.codeword       = 8'd0;
		push_res.codeword_valid = 1'b0;
		push_res.last           = 1'b0;
		push_res.status         = qrbm_pkg::ST_OK;
		if (hdr2_q) begin
			push_res.codeword       = hdr2_byte_q;
			push_res.codeword_valid = 1'b1;
		end else begin
			unique case (item_s1.req_type)
				qrbm_pkg::REQ_START: begin
					if (phase_q != qrbm_pkg::PH_IDLE) begin
						push_res.status = qrbm_pkg::ST_ORDER;
					end else if (too_long) begin
						push_res.status = qrbm_pkg::ST_TOO_LONG;
					end else begin
						// 16-bit count: its top nibble is zero for a 12-bit length
						push_res.codeword_valid = 1'b1;
						push_res.codeword = {qrbm_pkg::MODE_BYTE, cap_info.short_count ?
							item_s1.msg_length[7:4] : 4'd0};
					end
				end
				qrbm_pkg::REQ_DATA: begin
					if (!data_ok) begin
						push_res.status = qrbm_pkg::ST_ORDER;
					end else begin
						push_res.codeword_valid = 1'b1;
						push_res.codeword       = {held_q, item_s1.data_byte[7:4]};
					end
				end
				qrbm_pkg::REQ_DRAIN: begin
					if (phase_q != qrbm_pkg::PH_DRAIN) begin
						push_res.status = qrbm_pkg::ST_ORDER;
					end else begin
						push_res.codeword_valid = 1'b1;
						push_res.last           = drain_last;
						if (!term_q) begin
							push_res.codeword = {held_q, 4'd0};
						end else begin
							push_res.codeword = toggle_q ? qrbm_pkg::PAD_B : qrbm_pkg::PAD_A;
						end
					end
				end
				default: begin
					push_res.status = qrbm_pkg::ST_ORDER;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= qrbm_pkg::PH_IDLE;
			held_q       <= 4'd0;
			bytes_left_q <= 12'd0;
			pads_left_q  <= 12'd0;
			term_q       <= 1'b0;
			toggle_q     <= 1'b0;
			hdr2_q       <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			held_q       <= held_d;
			bytes_left_q <= bytes_left_d;
			pads_left_q  <= pads_left_d;
			term_q       <= term_d;
			toggle_q     <= toggle_d;
			hdr2_q       <= hdr2_d;
		end
	end

	always_ff @(posedge clk) begin
		hdr2_byte_q <= hdr2_byte_d;
	end

endmodule

/* rtl/core/qrbm_out_fifo.sv */
// Small result queue that parts the engine from the output handshake.
module qrbm_out_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  qrbm_pkg::result_t  push_res,
	output logic               full,
	output logic               out_valid,
	input  logic               out_ready,
	output qrbm_pkg::result_t  out_res
);

	localparam int PW = qrbm_pkg::PTR_W;
	localparam int CW = qrbm_pkg::CNT_W;

	qrbm_pkg::result_t mem_q [qrbm_pkg::OUT_DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              pop;

	assign full      = (count_q == CW'(qrbm_pkg::OUT_DEPTH));
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_res   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

endmodule

/* rtl/core/qrbm_checker.sv */
// Port-level checks on the packer's result stream, bound to the top level.
module qrbm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// error results carry a zero codeword and never close the stream
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0 && !m_tlast)
		else $error("error result carries data or last");

	// the closing codeword is a real codeword with ok status
	a_last_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[0] && m_tuser[2:1] == 2'd0)
		else $error("last on a non-codeword result");

	// a real codeword has ok status, an error result a nonzero one, and status code 3 never appears
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] ? m_tuser[2:1] == 2'd0 : m_tuser[2:1] != 2'd0)
			&& m_tuser[2:1] != 2'd3)
		else $error("status and codeword_valid disagree");

endmodule

bind qr_byte_mode_codeword_packer_top qrbm_checker u_qrbm_checker (.*);

/* dv/qr_byte_mode_codeword_packer_top_test.sv */
// Self-checking stream testbench for the QR byte-mode data codeword packer.
`timescale 1ns / 100ps

module qr_byte_mode_codeword_packer_top_test;

	localparam int VERSIONS = 40;
	localparam int SHORT_VERSIONS = 9;     // version index below this: 8-bit count
	localparam logic [3:0] MODE_NIBBLE = 4'h4;
	localparam logic [7:0] PAD_FIRST = 8'hEC;
	localparam logic [7:0] PAD_SECOND = 8'h11;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1150;
	localparam int HOLD_CYCLES = 300;

	// byte capacity, row = ec level, column = version index
	localparam logic [11:0] BYTE_CAP [4][40] = '{
		'{12'd17, 12'd32, 12'd53, 12'd78, 12'd106, 12'd134, 12'd154, 12'd192,
		  12'd230, 12'd271, 12'd321, 12'd367, 12'd425, 12'd458, 12'd520, 12'd586,
		  12'd644, 12'd718, 12'd792, 12'd858, 12'd929, 12'd1003, 12'd1091, 12'd1171,
		  12'd1273, 12'd1367, 12'd1465, 12'd1528, 12'd1628, 12'd1732, 12'd1840,
		  12'd1952, 12'd2068, 12'd2188, 12'd2303, 12'd2431, 12'd2563, 12'd2699,
		  12'd2809, 12'd2953},
		'{12'd14, 12'd26, 12'd42, 12'd62, 12'd84, 12'd106, 12'd122, 12'd152,
		  12'd180, 12'd213, 12'd251, 12'd287, 12'd331, 12'd362, 12'd412, 12'd450,
		  12'd504, 12'd560, 12'd624, 12'd666, 12'd711, 12'd779, 12'd857, 12'd911,
		  12'd997, 12'd1059, 12'd1125, 12'd1190, 12'd1264, 12'd1370, 12'd1452,
		  12'd1538, 12'd1628, 12'd1722, 12'd1809, 12'd1911, 12'd1989, 12'd2099,
		  12'd2213, 12'd2331},
		'{12'd11, 12'd20, 12'd32, 12'd46, 12'd60, 12'd74, 12'd86, 12'd108,
		  12'd130, 12'd151, 12'd177, 12'd203, 12'd241, 12'd258, 12'd292, 12'd322,
		  12'd364, 12'd394, 12'd442, 12'd482, 12'd509, 12'd565, 12'd611, 12'd661,
		  12'd715, 12'd751, 12'd805, 12'd868, 12'd908, 12'd982, 12'd1030,
		  12'd1112, 12'd1168, 12'd1228, 12'd1283, 12'd1351, 12'd1423, 12'd1499,
		  12'd1579, 12'd1663},
		'{12'd7, 12'd14, 12'd24, 12'd34, 12'd44, 12'd58, 12'd64, 12'd84,
		  12'd98, 12'd119, 12'd137, 12'd155, 12'd177, 12'd194, 12'd220, 12'd250,
		  12'd280, 12'd310, 12'd338, 12'd382, 12'd403, 12'd439, 12'd461, 12'd511,
		  12'd535, 12'd593, 12'd625, 12'd658, 12'd698, 12'd742, 12'd790,
		  12'd842, 12'd898, 12'd958, 12'd983, 12'd1051, 12'd1093, 12'd1139,
		  12'd1219, 12'd1273}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [7:0] data_byte, [19:8] msg_length, [23:20] zero
	logic [1:0]  s_tuser;   // [1:0] req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [7:0] codeword
	logic [2:0]  m_tuser;   // [0] codeword_valid, [2:1] status
	logic        m_tlast;
	logic        cfg_we;
	logic        cfg_addr;
	logic [5:0]  cfg_wdata;

	// codewords the packer still owes, oldest first
	qrbm_pkg::result_t pending_cw [$];
	int      bad_count = 0;
	int      items_sent = 0;

	// traffic shaping, shared with the sender and receiver
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	bit rx_hold_req = 1'b0;
	bit rx_holding = 1'b0;

	// predictor copy of the registers and the stream state
	logic [1:0]  cfg_lvl = 2'd0;
	logic [5:0]  cfg_ver = 6'd0;
	qrbm_pkg::phase_t st_phase = qrbm_pkg::PH_IDLE;
	logic [3:0]  st_nib = 4'd0;
	logic [11:0] st_bytes = 12'd0;
	logic [11:0] st_pads = 12'd0;
	logic        st_term = 1'b0;
	logic        st_odd = 1'b0;

	qr_byte_mode_codeword_packer_top #(
		.VERSION_COUNT(VERSIONS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// capacity for the current setting; versions past the table saturate
	function automatic logic [11:0] cap_now();
		int vi;
		vi = (int'(cfg_ver) >= VERSIONS) ? VERSIONS - 1 : int'(cfg_ver);
		return BYTE_CAP[cfg_lvl][vi];
	endfunction

	function automatic void push_codeword(logic [7:0] cw, logic lst);
		qrbm_pkg::result_t r;
		r.codeword = cw;
		r.codeword_valid = 1'b1;
		r.last = lst;
		r.status = qrbm_pkg::ST_OK;
		pending_cw.push_back(r);
	endfunction

	function automatic void push_reject(logic [1:0] st);
		qrbm_pkg::result_t r;
		r.codeword = 8'h00;
		r.codeword_valid = 1'b0;
		r.last = 1'b0;
		r.status = st;
		pending_cw.push_back(r);
	endfunction

	// expected codewords for one accepted item
	function automatic void pack_codewords(logic [1:0] req, logic [7:0] db, logic [11:0] len);
		logic [11:0] cap;
		logic [7:0]  cw;
		logic        lst;
		case (req)
			qrbm_pkg::REQ_START: begin
				cap = cap_now();
				if (st_phase != qrbm_pkg::PH_IDLE) begin
					push_reject(qrbm_pkg::ST_ORDER);
				end else if (len > cap) begin
					push_reject(qrbm_pkg::ST_TOO_LONG);
				end else begin
					st_bytes = len;
					st_pads = cap - len;
					st_term = 1'b0;
					st_odd = 1'b0;
					st_phase = (len == 12'd0) ? qrbm_pkg::PH_DRAIN : qrbm_pkg::PH_DATA;
					if (int'(cfg_ver) < SHORT_VERSIONS) begin
						push_codeword({MODE_NIBBLE, len[7:4]}, 1'b0);
					end else begin
						// 16-bit count: its top nibble is always zero for a 12-bit length
						push_codeword({MODE_NIBBLE, 4'h0}, 1'b0);
						push_codeword(len[11:4], 1'b0);
					end
					st_nib = len[3:0];
				end
			end
			qrbm_pkg::REQ_DATA: begin
				if (st_phase != qrbm_pkg::PH_DATA || st_bytes == 12'd0) begin
					push_reject(qrbm_pkg::ST_ORDER);
				end else begin
					push_codeword({st_nib, db[7:4]}, 1'b0);
					st_nib = db[3:0];
					st_bytes = st_bytes - 12'd1;
					if (st_bytes == 12'd0)
						st_phase = qrbm_pkg::PH_DRAIN;
				end
			end
			qrbm_pkg::REQ_DRAIN: begin
				if (st_phase != qrbm_pkg::PH_DRAIN) begin
					push_reject(qrbm_pkg::ST_ORDER);
				end else begin
					if (!st_term) begin
						cw = {st_nib, 4'h0};   // held nibble plus zero terminator
						st_term = 1'b1;
					end else begin
						cw = st_odd ? PAD_SECOND : PAD_FIRST;
						st_odd = ~st_odd;
						if (st_pads != 12'd0)
							st_pads = st_pads - 12'd1;
					end
					lst = (st_pads == 12'd0);
					push_codeword(cw, lst);
					if (lst) begin
						st_phase = qrbm_pkg::PH_IDLE;
						st_nib = 4'd0;
					end
				end
			end
			default: push_reject(qrbm_pkg::ST_ORDER);
		endcase
	endfunction

	// offer one item, hold it until accepted, then predict; called just after clk rises
	task automatic send_item(logic [1:0] req, logic [7:0] db, logic [11:0] len);
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {4'h0, len, db};
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		items_sent++;
		pack_codewords(req, db, len);
	endtask

	// an item of any kind except the one the current phase wants
	task automatic send_stray(logic [1:0] wanted);
		logic [1:0] req;
		do
			req = 2'($urandom);
		while (req == wanted);
		send_item(req, 8'($urandom), 12'($urandom));
	endtask

	// stop offering, let every owed codeword out, then give the pipe time to empty
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_cw.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// both registers in one burst, then a wait for the capacity lookup to follow
	task automatic set_config(logic [5:0] lvl_word, logic [5:0] ver);
		cfg_we <= 1'b1;
		cfg_addr <= qrbm_pkg::CFG_EC_LEVEL;
		cfg_wdata <= lvl_word;
		@(posedge clk);
		cfg_addr <= qrbm_pkg::CFG_VERSION;
		cfg_wdata <= ver;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_lvl = lvl_word[1:0];
		cfg_ver = ver;
		repeat (3) @(posedge clk);
	endtask

	// one whole symbol, steered by the predicted phase; strays mixed in when noisy
	task automatic run_symbol(logic [11:0] len, bit noisy);
		send_item(qrbm_pkg::REQ_START, 8'($urandom), len);
		while (st_phase == qrbm_pkg::PH_DATA) begin
			if (noisy && $urandom_range(0, 15) == 0)
				send_stray(qrbm_pkg::REQ_DATA);
			send_item(qrbm_pkg::REQ_DATA, 8'($urandom), 12'($urandom));
		end
		while (st_phase == qrbm_pkg::PH_DRAIN) begin
			if (noisy && $urandom_range(0, 15) == 0)
				send_stray(qrbm_pkg::REQ_DRAIN);
			send_item(qrbm_pkg::REQ_DRAIN, 8'($urandom), 12'($urandom));
		end
	endtask

	// registers come up as level L, version 1 (capacity 17); strays in idle are refused
	task automatic test_reset_state();
		send_item(qrbm_pkg::REQ_DATA, 8'hFF, 12'hFFF);
		send_item(qrbm_pkg::REQ_DRAIN, 8'h00, 12'h000);
		send_item(REQ_UNUSED, 8'hFF, 12'hFFF);
		send_item(qrbm_pkg::REQ_START, 8'hFF, 12'hFFF);   // far too long
		send_item(qrbm_pkg::REQ_START, 8'h00, 12'd18);    // one past capacity
	endtask

	// level H version 1: full message, busy start, misplaced data and drain items
	task automatic test_short_count();
		wait_idle();
		set_config(6'd3, 6'd0);
		send_item(qrbm_pkg::REQ_START, 8'h00, 12'd7);
		send_item(qrbm_pkg::REQ_START, 8'hFF, 12'd0);     // busy
		send_item(qrbm_pkg::REQ_DRAIN, 8'h00, 12'h000);   // drain during data
		send_item(qrbm_pkg::REQ_DATA, 8'h00, 12'hFFF);
		send_item(qrbm_pkg::REQ_DATA, 8'hFF, 12'h000);
		repeat (5) send_item(qrbm_pkg::REQ_DATA, 8'($urandom), 12'($urandom));
		send_item(qrbm_pkg::REQ_DATA, 8'hA5, 12'h000);    // data once the count is used up
		send_item(REQ_UNUSED, 8'h00, 12'h000);
		send_item(qrbm_pkg::REQ_DRAIN, 8'h00, 12'h000);   // terminator is also the last codeword
	endtask

	// zero length goes straight to draining; level word has its spare bits set
	task automatic test_empty_message();
		wait_idle();
		set_config(6'h3F, 6'd0);
		run_symbol(12'd0, 1'b0);
	endtask

	// saturated version index and capacity edges at the top of the table
	task automatic test_largest_symbol();
		wait_idle();
		set_config(6'd0, 6'd39);
		send_item(qrbm_pkg::REQ_START, 8'h00, 12'd2954);
		wait_idle();
		set_config(6'd3, 6'd63);
		send_item(qrbm_pkg::REQ_START, 8'h00, 12'd1274);
	endtask

	// receiver stalls for a long stretch while items keep coming
	task automatic test_backpressure();
		wait_idle();
		set_config(6'd1, 6'd1);
		rx_hold_req = 1'b1;
		wait (rx_holding);
		run_symbol(12'd20, 1'b0);
	endtask

	task automatic test_random_symbols();
		int          first;
		logic [5:0]  ver;
		logic [11:0] cap;
		logic [11:0] len;
		int          pick;
		first = items_sent;
		while (items_sent - first < RANDOM_ITEMS) begin
			wait_idle();
			if ($urandom_range(0, 9) == 0) begin
				// big versions: only too-long starts and a refused stray, to keep the run short
				set_config(6'($urandom), 6'($urandom_range(10, 63)));
				cap = cap_now();
				send_item(qrbm_pkg::REQ_START, 8'($urandom),
					12'($urandom_range(cap + 1, 4095)));
				send_stray(qrbm_pkg::REQ_START);
			end else begin
				ver = 6'($urandom_range(0, 10));
				set_config(6'($urandom), ver);
				cap = cap_now();
				pick = $urandom_range(0, 7);
				if (pick == 0)
					len = 12'd0;
				else if (pick == 1)
					len = cap;
				else
					len = 12'($urandom_range(1, cap));
				if (pick == 2)
					send_item(qrbm_pkg::REQ_START, 8'($urandom), cap + 12'd1);
				if ($urandom_range(0, 5) == 0)
					send_stray(qrbm_pkg::REQ_START);
				run_symbol(len, 1'b1);
			end
		end
	endtask

	// closing stretch at full rate on both sides, around the count-width boundary
	task automatic test_no_idle();
		wait_idle();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		for (int v = 8; v <= 10; v++) begin
			wait_idle();
			set_config(6'($urandom), 6'(v));
			run_symbol(12'($urandom_range(0, cap_now())), 1'b1);
		end
	endtask

	// receiver: random stall bursts, plus one long counted hold on request
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				m_tready <= 1'b0;
				rx_holding = 1'b1;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				rx_hold_req = 1'b0;
				rx_holding = 1'b0;
			end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// checker: every accepted result against the oldest owed codeword
	always @(posedge clk) begin
		qrbm_pkg::result_t want;
		if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (pending_cw.size() == 0) begin
				bad_count++;
				if (bad_count <= 10)
					$display("unexpected result: cw %h valid %b last %b status %0d",
						m_tdata, m_tuser[0], m_tlast, m_tuser[2:1]);
			end else begin
				want = pending_cw.pop_front();
				if (m_tdata !== want.codeword || m_tuser[0] !== want.codeword_valid ||
						m_tlast !== want.last || m_tuser[2:1] !== want.status) begin
					bad_count++;
					if (bad_count <= 10)
						$display("mismatch: want %h/%b/%b/%0d got %h/%b/%b/%0d",
							want.codeword, want.codeword_valid, want.last, want.status,
							m_tdata, m_tuser[0], m_tlast, m_tuser[2:1]);
				end
			end
		end
	end

	// hard stop well past the slowest legal run
	initial begin
		#5_000_000;
		$display("qr_byte_mode_codeword_packer_top_test NOT OK");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= qrbm_pkg::REQ_START;
		cfg_we <= 1'b0;
		cfg_addr <= qrbm_pkg::CFG_EC_LEVEL;
		cfg_wdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		test_reset_state();
		test_short_count();
		test_empty_message();
		test_largest_symbol();
		test_backpressure();
		test_random_symbols();
		test_no_idle();

		wait_idle();
		repeat (16) @(posedge clk);
		if (bad_count == 0 && pending_cw.size() == 0)
			$display("qr_byte_mode_codeword_packer_top_test OK");
		else
			$display("qr_byte_mode_codeword_packer_top_test NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/qrbm_pkg.sv
rtl/core/qrbm_cap_rom.sv
rtl/core/qrbm_engine.sv
rtl/core/qrbm_out_fifo.sv
rtl/core/qr_byte_mode_codeword_packer_top.sv
rtl/core/qrbm_checker.sv
dv/qr_byte_mode_codeword_packer_top_test.sv
